FILE: rtl/arcp_pkg.sv
// ============================================================================
// arcp_pkg
// Shared widths, angle constants, CORDIC arctangent table and stage record
// types for the arc point-to-parameter pipeline.
// ============================================================================
`default_nettype none

package arcp_pkg;

    localparam int XW     = 60;  // CORDIC x/y datapath width
    localparam int ZW     = 33;  // angle width, Q4.28 plus headroom
    localparam int AW     = 35;  // angle compare width
    localparam int CFG_IW = 3;   // configuration index width

    localparam logic signed [ZW-1:0] ANG_PI     = 33'sd843314857;
    localparam logic signed [ZW-1:0] ANG_TWO_PI = 33'sd1686629714;
    localparam logic signed [AW-1:0] PI_W       = 35'sd843314857;
    localparam logic signed [AW-1:0] TWO_PI_W   = 35'sd1686629714;

    typedef enum logic [CFG_IW-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_START_ANGLE = 3'd2,
        REG_SWEEP_ANGLE = 3'd3,
        REG_PARAM_START = 3'd4,
        REG_PARAM_END   = 3'd5,
        REG_MIN_RADIUS  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic                 bad;
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cord_t;

    typedef struct packed {
        logic        bad;
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
    } div_t;

    // atan(2^-i) in Q4.28, rounded to nearest
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd210828714;
            5'd1:    v = 32'd124459457;
            5'd2:    v = 32'd65760959;
            5'd3:    v = 32'd33381290;
            5'd4:    v = 32'd16755422;
            5'd5:    v = 32'd8385879;
            5'd6:    v = 32'd4193963;
            5'd7:    v = 32'd2097109;
            5'd8:    v = 32'd1048571;
            5'd9:    v = 32'd524287;
            5'd10:   v = 32'd262144;
            5'd11:   v = 32'd131072;
            5'd12:   v = 32'd65536;
            5'd13:   v = 32'd32768;
            5'd14:   v = 32'd16384;
            5'd15:   v = 32'd8192;
            5'd16:   v = 32'd4096;
            5'd17:   v = 32'd2048;
            5'd18:   v = 32'd1024;
            5'd19:   v = 32'd512;
            5'd20:   v = 32'd256;
            5'd21:   v = 32'd128;
            5'd22:   v = 32'd64;
            5'd23:   v = 32'd32;
            5'd24:   v = 32'd16;
            5'd25:   v = 32'd8;
            5'd26:   v = 32'd4;
            5'd27:   v = 32'd2;
            5'd28:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Fold an angle into [-pi, pi); inputs stay within a few turns
    function automatic logic signed [ZW-1:0] wrap_angle(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] r;
        r = a;
        for (int i = 0; i < 4; i++) begin
            if (r >= PI_W) begin
                r = r - TWO_PI_W;
            end
            else if (r < -PI_W) begin
                r = r + TWO_PI_W;
            end
        end
        return r[ZW-1:0];
    endfunction

    function automatic logic [AW-1:0] abs_w(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] n;
        n = -v;
        return v[AW-1] ? AW'(n) : AW'(v);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/arc_point_to_param_unit.sv
// ============================================================================
// arc_point_to_param_unit
// Nearest-point curve parameter on a circular arc: CORDIC angle, span clamp,
// sweep normalization and a pipelined divide for the interpolation.
// ============================================================================
// Takes one point per clock while in_stall is low and returns one beat per
// point, in order. The path is a fixed pipeline: input register, CORDIC
// setup, one register per CORDIC step (CORDIC_STEPS, at most 32), six
// span/interpolation stages, one product stage, a 32-stage restoring divider
// and a result stage, then a two-entry output buffer. The output buffer lets
// the pipeline keep taking points while a finished beat waits on stall.
// Configuration feeds a few registered derived values, so writes must be
// done a few cycles before the next point.
`default_nettype none

module arc_point_to_param_unit #(
    parameter int CORDIC_STEPS = 28
) (
    input  wire  logic                              clk,
    input  wire  logic                              rst_n,
    input  wire  logic                              cfg_we,
    input  wire  logic [arcp_pkg::CFG_IW-1:0]       cfg_idx,
    input  wire  logic [31:0]                       cfg_wdata,
    input  wire  logic                              in_valid,
    output logic                                    in_stall,
    input  wire  logic signed [31:0]                point_x,
    input  wire  logic signed [31:0]                point_y,
    output logic                                    out_valid,
    input  wire  logic                              out_stall,
    output logic signed [31:0]                      param_value,
    output logic                                    bad_point
);
    import arcp_pkg::*;

    localparam int NS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int NP = 6;   // span and interpolation stages
    localparam int ND = 32;  // divider stages

    // ---------------- configuration ----------------
    logic signed [31:0] cx_reg, cy_reg, sa_reg, sw_reg, ps_reg, pe_reg;
    logic [30:0]        mr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            sa_reg <= '0;
            sw_reg <= '0;
            ps_reg <= '0;
            pe_reg <= '0;
            mr_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_CENTER_X:    cx_reg <= cfg_wdata;
                REG_CENTER_Y:    cy_reg <= cfg_wdata;
                REG_START_ANGLE: sa_reg <= cfg_wdata;
                REG_SWEEP_ANGLE: sw_reg <= cfg_wdata;
                REG_PARAM_START: ps_reg <= cfg_wdata;
                REG_PARAM_END:   pe_reg <= cfg_wdata;
                REG_MIN_RADIUS:  mr_reg <= cfg_wdata[30:0];
                default:         ;
            endcase
        end
    end

    // ---------------- derived configuration ----------------
    logic signed [32:0] sa_ext, sw_ext, end_sum, lo_ang, hi_ang, sw_neg, pdiff, pdiff_neg;
    logic [31:0]        sw_mag;
    logic [61:0]        mr_sq;

    logic signed [ZW-1:0] dv_t0_reg, dv_t1_reg;
    logic                 dv_full_reg, dv_pos_reg, dv_dneg_reg;
    logic [31:0]          dv_den_reg, dv_dmag_reg;
    logic [61:0]          dv_mr2_reg;

    always_comb
    begin
        sa_ext    = {sa_reg[31], sa_reg};
        sw_ext    = {sw_reg[31], sw_reg};
        end_sum   = sa_ext + sw_ext;
        lo_ang    = sw_reg[31] ? end_sum : sa_ext;
        hi_ang    = sw_reg[31] ? sa_ext : end_sum;
        sw_neg    = -sw_ext;
        sw_mag    = sw_reg[31] ? sw_neg[31:0] : sw_reg[31:0];
        pdiff     = {pe_reg[31], pe_reg} - {ps_reg[31], ps_reg};
        pdiff_neg = -pdiff;
        mr_sq     = 62'(mr_reg) * 62'(mr_reg);
    end

    always_ff @(posedge clk)
    begin
        dv_t0_reg   <= wrap_angle({{(AW-33){lo_ang[32]}}, lo_ang});
        dv_t1_reg   <= wrap_angle({{(AW-33){hi_ang[32]}}, hi_ang});
        dv_full_reg <= {1'b0, sw_mag} >= $unsigned(ANG_TWO_PI);
        dv_pos_reg  <= !sw_reg[31] && (sw_reg != '0);
        dv_den_reg  <= sw_mag;
        dv_dneg_reg <= pdiff[32];
        dv_dmag_reg <= pdiff[32] ? pdiff_neg[31:0] : pdiff[31:0];
        dv_mr2_reg  <= mr_sq;
    end

    // ---------------- flow control ----------------
    logic        a_vld_reg;
    logic [NS:0] cr_vld_reg;
    logic [NP:1] p_vld_reg;
    logic [ND:0] dv_vld_reg;
    logic        f_vld_reg;
    logic [1:0]  fifo_cnt_reg;
    logic        pop, push, adv;

    assign pop      = out_valid && !out_stall;
    assign adv      = !f_vld_reg || (fifo_cnt_reg != 2'd2) || pop;
    assign push     = f_vld_reg && adv;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            cr_vld_reg <= '0;
            p_vld_reg  <= '0;
            dv_vld_reg <= '0;
            f_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg  <= in_valid;
            cr_vld_reg <= {cr_vld_reg[NS-1:0], a_vld_reg};
            p_vld_reg  <= {p_vld_reg[NP-1:1], cr_vld_reg[NS]};
            dv_vld_reg <= {dv_vld_reg[ND-1:0], p_vld_reg[NP]};
            f_vld_reg  <= dv_vld_reg[ND];
        end
    end

    // ---------------- stage A: center offset ----------------
    logic signed [32:0] a_dx_reg, a_dy_reg;
    logic               a_sw0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dx_reg  <= {point_x[31], point_x} - {cx_reg[31], cx_reg};
            a_dy_reg  <= {point_y[31], point_y} - {cy_reg[31], cy_reg};
            a_sw0_reg <= (sw_reg == '0);
        end
    end

    // ---------------- stage B: radius check setup, CORDIC prerotation ----------------
    cord_t             cr_reg  [0:NS];
    cord_t             cr_next [0:NS];
    logic [32:0]       ax_abs, ay_abs;
    logic signed [32:0] dx_neg, dy_neg;
    logic signed [XW-1:0] xe, ye;
    logic [30:0]       b_ax_reg, b_ay_reg;
    logic              b_small_reg;
    logic [61:0]       sq_x_reg, sq_y_reg;
    logic              sm1_reg;
    logic              near_hit;

    always_comb
    begin
        dx_neg = -a_dx_reg;
        dy_neg = -a_dy_reg;
        ax_abs = a_dx_reg[32] ? dx_neg : a_dx_reg;
        ay_abs = a_dy_reg[32] ? dy_neg : a_dy_reg;
        xe     = {{(XW-57){a_dx_reg[32]}}, a_dx_reg, 24'b0};
        ye     = {{(XW-57){a_dy_reg[32]}}, a_dy_reg, 24'b0};
        cr_next[0].bad  = a_sw0_reg;
        cr_next[0].zero = (a_dx_reg == '0) && (a_dy_reg == '0);
        if (a_dx_reg[32])
        begin
            // rotate the left half-plane by pi first
            cr_next[0].x = -xe;
            cr_next[0].y = -ye;
            cr_next[0].z = a_dy_reg[32] ? -ANG_PI : ANG_PI;
        end
        else
        begin
            cr_next[0].x = xe;
            cr_next[0].y = ye;
            cr_next[0].z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_ax_reg    <= ax_abs[30:0];
            b_ay_reg    <= ay_abs[30:0];
            b_small_reg <= (ax_abs < {2'b0, mr_reg}) && (ay_abs < {2'b0, mr_reg});
            sq_x_reg    <= 62'(b_ax_reg) * 62'(b_ax_reg);
            sq_y_reg    <= 62'(b_ay_reg) * 62'(b_ay_reg);
            sm1_reg     <= b_small_reg;
        end
    end

    assign near_hit = sm1_reg &&
        (({1'b0, sq_x_reg} + {1'b0, sq_y_reg}) < {1'b0, dv_mr2_reg});

    // ---------------- CORDIC vectoring, one step per stage ----------------
    for (genvar k = 1; k <= NS; k++)
    begin : g_cordic
        localparam int SH = k - 1;
        logic signed [XW-1:0] xs, ys;
        logic signed [ZW-1:0] da;

        always_comb
        begin
            xs = cr_reg[k-1].x;
            ys = cr_reg[k-1].y;
            xs = xs >>> SH;
            ys = ys >>> SH;
            da = $signed({1'b0, atan_lut(5'(SH))});
            cr_next[k] = cr_reg[k-1];
            if (!cr_reg[k-1].y[XW-1])
            begin
                cr_next[k].x = cr_reg[k-1].x + ys;
                cr_next[k].y = cr_reg[k-1].y - xs;
                cr_next[k].z = cr_reg[k-1].z + da;
            end
            else
            begin
                cr_next[k].x = cr_reg[k-1].x - ys;
                cr_next[k].y = cr_reg[k-1].y + xs;
                cr_next[k].z = cr_reg[k-1].z - da;
            end
            if (k == 2)
            begin
                cr_next[k].bad = cr_reg[k-1].bad | near_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= NS; k++)
            begin
                cr_reg[k] <= cr_next[k];
            end
        end
    end

    // ---------------- span clamp and sweep normalization ----------------
    logic signed [ZW-1:0] p1_t_reg, p3_near_reg;
    logic signed [AW-1:0] t_w, t0_w, t1_w, near_w, dn_w;
    logic [AW-1:0]        d0a, d0b, d1a, d1b;
    logic [AW-1:0]        p2_d0_reg, p2_d1_reg;
    logic signed [ZW-1:0] p2_t_reg;
    logic                 p2_in_reg;
    logic [31:0]          p4_dn_reg, p5_num_reg;
    logic [47:0]          p6_pl_reg, p6_ph_reg;
    logic                 p1_bad_reg, p2_bad_reg, p3_bad_reg, p4_bad_reg, p5_bad_reg;
    logic                 p6_bad_reg;
    logic                 in_span;

    always_comb
    begin
        t_w    = {{(AW-ZW){p1_t_reg[ZW-1]}}, p1_t_reg};
        t0_w   = {{(AW-ZW){dv_t0_reg[ZW-1]}}, dv_t0_reg};
        t1_w   = {{(AW-ZW){dv_t1_reg[ZW-1]}}, dv_t1_reg};
        in_span = dv_full_reg ||
                  ((t0_w <= t_w) && (t_w <= t1_w)) ||
                  ((t_w <= t1_w) && (t1_w < t0_w)) ||
                  ((t1_w < t0_w) && (t0_w <= t_w));
        d0a = abs_w(t_w - t0_w);
        d0b = abs_w(t_w - TWO_PI_W - t0_w);
        d1a = abs_w(t_w - t1_w);
        d1b = abs_w(t_w + TWO_PI_W - t1_w);
        near_w = {{(AW-ZW){p3_near_reg[ZW-1]}}, p3_near_reg};
        dn_w   = dv_pos_reg ? (near_w - t0_w) : (t1_w - near_w);
        if (dn_w < 0)
        begin
            dn_w = dn_w + TWO_PI_W;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // clamp the CORDIC angle; a point on the center reads as zero
            if (cr_reg[NS].zero)
            begin
                p1_t_reg <= '0;
            end
            else if (cr_reg[NS].z > ANG_PI)
            begin
                p1_t_reg <= ANG_PI;
            end
            else if (cr_reg[NS].z < -ANG_PI)
            begin
                p1_t_reg <= -ANG_PI;
            end
            else
            begin
                p1_t_reg <= cr_reg[NS].z;
            end
            p1_bad_reg <= cr_reg[NS].bad;

            p2_t_reg   <= p1_t_reg;
            p2_in_reg  <= in_span;
            p2_d0_reg  <= (d0a < d0b) ? d0a : d0b;
            p2_d1_reg  <= (d1a < d1b) ? d1a : d1b;
            p2_bad_reg <= p1_bad_reg;

            // snap outside the span; a tie goes to the low end of the span (t0)
            if (p2_in_reg)
            begin
                p3_near_reg <= p2_t_reg;
            end
            else if (p2_d0_reg <= p2_d1_reg)
            begin
                p3_near_reg <= dv_t0_reg;
            end
            else
            begin
                p3_near_reg <= dv_t1_reg;
            end
            p3_bad_reg <= p2_bad_reg;

            p4_dn_reg  <= dn_w[31:0];
            p4_bad_reg <= p3_bad_reg;

            p5_num_reg <= (p4_dn_reg > dv_den_reg) ? dv_den_reg : p4_dn_reg;
            p5_bad_reg <= p4_bad_reg;

            p6_pl_reg  <= 48'(dv_dmag_reg) * 48'(p5_num_reg[15:0]);
            p6_ph_reg  <= 48'(dv_dmag_reg) * 48'(p5_num_reg[31:16]);
            p6_bad_reg <= p5_bad_reg;
        end
    end

    // ---------------- restoring divide, one quotient bit per stage ----------------
    div_t        dv_reg  [0:ND];
    div_t        dv_next [0:ND];
    logic [63:0] prod;

    always_comb
    begin
        prod = {p6_ph_reg, 16'b0} + {16'b0, p6_pl_reg};
        dv_next[0].bad = p6_bad_reg;
        dv_next[0].rem = prod[63:32];
        dv_next[0].low = prod[31:0];
        dv_next[0].quo = '0;
    end

    for (genvar j = 1; j <= ND; j++)
    begin : g_div
        logic [32:0] trial, diff;
        logic        ge;

        always_comb
        begin
            trial = {dv_reg[j-1].rem, dv_reg[j-1].low[31]};
            ge    = trial >= {1'b0, dv_den_reg};
            diff  = trial - {1'b0, dv_den_reg};
            dv_next[j].bad = dv_reg[j-1].bad;
            dv_next[j].rem = ge ? diff[31:0] : trial[31:0];
            dv_next[j].low = {dv_reg[j-1].low[30:0], 1'b0};
            dv_next[j].quo = {dv_reg[j-1].quo[30:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j <= ND; j++)
            begin
                dv_reg[j] <= dv_next[j];
            end
        end
    end

    // ---------------- result ----------------
    logic [32:0]        q_mag, q_neg;
    logic signed [32:0] res_sum;
    logic signed [31:0] f_val_reg;
    logic               f_bad_reg;

    always_comb
    begin
        q_mag   = {1'b0, dv_reg[ND].quo};
        q_neg   = -q_mag;
        res_sum = {ps_reg[31], ps_reg} + $signed(dv_dneg_reg ? q_neg : q_mag);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_bad_reg <= dv_reg[ND].bad;
            f_val_reg <= dv_reg[ND].bad ? '0 : res_sum[31:0];
        end
    end

    // ---------------- output buffer ----------------
    logic signed [31:0] e0_val_reg, e1_val_reg;
    logic               e0_bad_reg, e1_bad_reg;
    logic [1:0]         cnt_after_pop;

    assign cnt_after_pop = fifo_cnt_reg - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_cnt_reg <= '0;
        end
        else
        begin
            fifo_cnt_reg <= cnt_after_pop + {1'b0, push};
        end
    end

    always_ff @(posedge clk)
    begin
        // drop the new beat into the first free slot, else advance the second entry
        if (push && (cnt_after_pop == 2'd0))
        begin
            e0_val_reg <= f_val_reg;
            e0_bad_reg <= f_bad_reg;
        end
        else if (pop)
        begin
            e0_val_reg <= e1_val_reg;
            e0_bad_reg <= e1_bad_reg;
        end
        if (push && (cnt_after_pop != 2'd0))
        begin
            e1_val_reg <= f_val_reg;
            e1_bad_reg <= f_bad_reg;
        end
    end

    assign out_valid   = (fifo_cnt_reg != 2'd0);
    assign param_value = e0_val_reg;
    assign bad_point   = e0_bad_reg;

    // ---------------- assertions ----------------
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_point) |-> (param_value == '0))
        else $error("flagged beat carries a nonzero parameter");

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_cnt_reg != 2'd3))
        else $error("output buffer overfilled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (f_vld_reg && (fifo_cnt_reg == 2'd2) && out_stall))
        else $error("input held off without a full, stalled output");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> out_valid && (fifo_cnt_reg == $past(fifo_cnt_reg) + 2'd1))
        else $error("pushed beat not counted");

endmodule

`default_nettype wire

FILE: tb/arc_point_to_param_unit_tb.sv
// ----------------------------------------------------------------------------
// arc_point_to_param_unit testbench
// Drives query points through the arc parameter pipeline under random idle
// and stall, predicts each beat with a behavioral model of the CORDIC angle,
// span clamp and interpolation, and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arc_point_to_param_unit_tb;
    import arcp_pkg::*;

    localparam int  STEPS      = 28;
    localparam int  LATENCY    = STEPS + 50;
    localparam int  N_RANDOM   = 1281;
    localparam longint PI_Q    = 64'sd843314857;
    localparam longint TWO_PI_Q = 64'sd1686629714;
    localparam longint LIMIT   = 2000000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_IW-1:0]  cfg_idx;
    logic [31:0]        cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] param_value;
    logic               bad_point;

    typedef struct {
        logic signed [31:0] param;
        logic               bad;
    } arc_result_t;

    // Arc configuration mirror
    typedef struct {
        longint cx, cy, start, sweep, p0, p1, rmin;
    } arc_cfg_t;

    function automatic longint atan_step(int i);
        longint t[32] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                          8385879, 4193963, 2097109, 1048571, 524287, 262144,
                          131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
                          512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};
        return t[i];
    endfunction

    function automatic longint fold_angle(longint a);
        longint r;
        r = (a + PI_Q) % TWO_PI_Q;
        if (r < 0)
            r += TWO_PI_Q;
        return r - PI_Q;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint point_angle(longint dx, longint dy);
        longint x, y, z, xs, ys;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx <<< 24;
        y = dy <<< 24;
        if (x < 0)
        begin
            z = (dy >= 0) ? PI_Q : -PI_Q;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += atan_step(i);
            end
            else
            begin
                x -= ys; y += xs; z -= atan_step(i);
            end
        end
        if (z > PI_Q) z = PI_Q;
        if (z < -PI_Q) z = -PI_Q;
        return z;
    endfunction

    function automatic longint snap_to_span(longint t, longint lo, longint hi);
        longint t0, t1, d0, d1, a, b;
        if (hi >= lo + TWO_PI_Q)
            return t;
        t0 = fold_angle(lo);
        t1 = fold_angle(hi);
        if (t0 <= t && t <= t1) return t;
        if (t <= t1 && t1 < t0) return t;
        if (t1 < t0 && t0 <= t) return t;
        a = mag(t - t0); b = mag(t - TWO_PI_Q - t0);
        d0 = a < b ? a : b;
        a = mag(t - t1); b = mag(t + TWO_PI_Q - t1);
        d1 = a < b ? a : b;
        return (d0 <= d1) ? t0 : t1;
    endfunction

    function automatic arc_result_t nearest_param(arc_cfg_t c, logic signed [31:0] px,
                                                  logic signed [31:0] py);
        arc_result_t r;
        longint dx, dy, ax, ay, t, lo, hi, near_a, dn, den, num;
        logic [63:0] r2, d2;
        logic close;
        dx = longint'(px) - c.cx;
        dy = longint'(py) - c.cy;
        ax = mag(dx); ay = mag(dy);
        close = 1'b0;
        if (ax < c.rmin && ay < c.rmin)
        begin
            r2 = c.rmin * c.rmin;
            d2 = ax * ax + ay * ay;
            close = d2 < r2;
        end
        if (c.sweep == 0 || close)
        begin
            r.param = '0; r.bad = 1'b1;
            return r;
        end
        t = point_angle(dx, dy);
        lo = (c.sweep < 0) ? c.start + c.sweep : c.start;
        hi = (c.sweep < 0) ? c.start : c.start + c.sweep;
        near_a = snap_to_span(t, lo, hi);
        dn = (c.sweep > 0) ? near_a - fold_angle(lo) : fold_angle(hi) - near_a;
        if (dn < 0) dn += TWO_PI_Q;
        den = mag(c.sweep);
        num = dn;
        if (num < 0) num = 0;
        if (num > den) num = den;
        r.param = 32'(c.p0 + ((c.p1 - c.p0) * num) / den);
        r.bad = 1'b0;
        return r;
    endfunction

    class arc_scoreboard;
        arc_result_t pending[$];
        int          errors;

        function void note_point(arc_cfg_t c, logic signed [31:0] px, logic signed [31:0] py);
            pending.push_back(nearest_param(c, px, py));
        endfunction

        function void check_beat(logic signed [31:0] pv, logic bp);
            arc_result_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected beat param=%0d bad=%0b", pv, bp);
                return;
            end
            e = pending.pop_front();
            if (e.param !== pv || e.bad !== bp)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: expected param=%0d bad=%0b, got param=%0d bad=%0b",
                             e.param, e.bad, pv, bp);
            end
        endfunction
    endclass

    arc_scoreboard board;
    arc_cfg_t      arc;
    longint        cycles;
    bit            hold_output;

    arc_point_to_param_unit #(.CORDIC_STEPS(STEPS)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .param_value(param_value), .bad_point(bad_point)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
            board.check_beat(param_value, bad_point);
    end

    // Receiver: random stall per beat, or a long hold when asked
    initial
    begin
        int w;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_output)
                out_stall <= 1'b1;
            else
            begin
                w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                if (w > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (w) @(negedge clk);
                end
                out_stall <= 1'b0;
                @(posedge clk);
                while (!out_valid) @(posedge clk);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= v;
        case (idx)
            REG_CENTER_X:    arc.cx    = longint'(signed'(v));
            REG_CENTER_Y:    arc.cy    = longint'(signed'(v));
            REG_START_ANGLE: arc.start = longint'(signed'(v));
            REG_SWEEP_ANGLE: arc.sweep = longint'(signed'(v));
            REG_PARAM_START: arc.p0    = longint'(signed'(v));
            REG_PARAM_END:   arc.p1    = longint'(signed'(v));
            default:         arc.rmin  = longint'(v[30:0]);
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_arc(logic [31:0] cx, logic [31:0] cy, logic [31:0] st,
                           logic [31:0] sw, logic [31:0] p0, logic [31:0] p1,
                           logic [31:0] rmin);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_START_ANGLE, st);
        write_reg(REG_SWEEP_ANGLE, sw);
        write_reg(REG_PARAM_START, p0);
        write_reg(REG_PARAM_END, p1);
        write_reg(REG_MIN_RADIUS, rmin);
        repeat (8) @(negedge clk);
    endtask

    // Send one point; gap drawn per beat, sometimes none. Valid stays up on
    // return so back-to-back beats leave no hole.
    task automatic send_point(logic signed [31:0] px, logic signed [31:0] py, bit gaps);
        int w;
        w = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 15) : 0;
        if (w > 0)
        begin
            in_valid <= 1'b0;
            repeat (w) @(negedge clk);
        end
        in_valid <= 1'b1;
        point_x  <= px;
        point_y  <= py;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_point(arc, px, py);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_near(int span);
        return 32'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [31:0] rand_angle();
        return 32'(int'($urandom_range(0, 32'd1800000000)) - 900000000);
    endfunction

    initial
    begin
        logic signed [31:0] qx, qy;
        int ang;
        board        = new();
        arc          = '{0, 0, 0, 0, 0, 0, 0};
        cycles       = 0;
        hold_output  = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = REG_CENTER_X;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        point_x   = '0;
        point_y   = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero sweep after reset flags every point
        send_point(32'sd65536, 32'sd0, 1'b0);
        drain();

        // Quarter arc, unit center offsets
        set_arc(32'h0001_0000, 32'hFFFF_0000, 32'd0, 32'd421657428, 32'd0,
                32'h0010_0000, 32'h0000_8000);
        send_point(32'h0001_0000, 32'hFFFF_0000, 1'b0);       // on center
        send_point(32'h0001_4000, 32'hFFFF_0000, 1'b0);       // inside radius
        send_point(32'h0003_0000, 32'hFFFF_0000, 1'b0);       // angle 0
        send_point(32'h0001_0000, 32'h0001_0000, 1'b0);       // angle pi/2
        send_point(32'hFFFF_0000, 32'hFFFF_0000, 1'b0);       // angle pi
        send_point(32'hFFFF_0000, 32'hFFFF_FFFF, 1'b0);       // angle just below pi
        send_point(32'hFFFF_0000, 32'hFFFD_0000, 1'b0);       // equidistant -3pi/4
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        drain();

        // Negative sweep straddling pi, extreme parameters
        set_arc(32'd0, 32'd0, 32'd900000000, 32'hE000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'd0);
        send_point(32'd0, 32'd0, 1'b0);                        // center, radius zero
        send_point(32'hFFFF_0000, 32'd1, 1'b0);
        send_point(32'hFFFF_0000, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h0001_0000, 32'd0, 1'b0);
        send_point(32'd0, 32'hFFFF_0000, 1'b0);
        drain();

        // Full turn and beyond: no clamping
        set_arc(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h0000_0000, 1'b0);
        drain();

        // Random phases with fresh arcs
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_arc(rand_near(1 << 20), rand_near(1 << 20), rand_angle(),
                           32'd843314857, $urandom, $urandom, $urandom_range(0, 1 << 18));
                1: set_arc(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                2: set_arc($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
                default: set_arc(rand_near(1 << 22), rand_near(1 << 22), rand_angle(),
                                 rand_angle(), $urandom, $urandom,
                                 $urandom_range(0, 1 << 17));
            endcase
            if (ph == 3)
            begin
                // Hold output long enough for the pipe and input to back up
                fork
                    begin
                        hold_output = 1'b1;
                        repeat (LATENCY * 3) @(posedge clk);
                        hold_output = 1'b0;
                    end
                    for (int k = 0; k < 150; k++)
                        send_point($urandom, $urandom, 1'b0);
                join
            end
            for (int k = 0; k < N_RANDOM / 7; k++)
            begin
                case ($urandom_range(0, 5))
                    0, 1:
                    begin
                        qx = $urandom;
                        qy = $urandom;
                    end
                    2:
                    begin
                        qx = 32'(arc.cx + longint'(signed'(rand_near(1 << 18))));
                        qy = 32'(arc.cy + longint'(signed'(rand_near(1 << 18))));
                    end
                    default:
                    begin
                        qx = 32'(arc.cx + longint'(signed'(rand_near(1 << 24))));
                        qy = 32'(arc.cy + longint'(signed'(rand_near(1 << 24))));
                    end
                endcase
                ang = $urandom_range(0, 1);
                send_point(qx, qy, ang == 1 || k % 50 < 40);
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: arc_point_to_param_unit.f
rtl/arcp_pkg.sv
rtl/arc_point_to_param_unit.sv
tb/arc_point_to_param_unit_tb.sv
